// ----- src/tsd_pkg.sv -----
// shared types and constants for the tar stream deframer
// used by tsd_parser and tar_stream_deframer; no dependencies
`default_nettype none

package tsd_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int SIZE_W      = 33;
    localparam int BLK_W       = 32;
    localparam int TDATA_W     = 80;

    localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] SIZE_START  = OFF_W'(124);
    localparam logic [OFF_W-1:0] SIZE_END    = OFF_W'(136);
    localparam logic [OFF_W-1:0] TYPE_OFFSET = OFF_W'(156);
    localparam logic [OFF_W-1:0] MAGIC_START = OFF_W'(257);
    localparam logic [OFF_W-1:0] MAGIC_END   = OFF_W'(262);

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // register index of extract_mode, decoded from the word address
    localparam logic REG_EXTRACT = 1'b0;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_HEADER = 3'd2,
        KIND_END    = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_UNSUPPORTED = 2'd0,
        ERR_UNEXPECTED  = 2'd1,
        ERR_NOT_TAR     = 2'd2,
        ERR_LONE_ZERO   = 2'd3
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         out_byte;
        logic [SIZE_W-1:0]  member_size;
        logic               last_of_member;
        t_err               error_code;
        logic [BLK_W-1:0]   blocks_seen;
    } t_result;

endpackage

`default_nettype wire

// ----- src/tar_stream_deframer.sv -----
// tar stream deframer top level: one word in, one result word out.
// latency: a result is valid the cycle after its input word is accepted.
// throughput: one word per cycle; the output register is bypassed for ready,
// so input stalls only while a result is held and the master side is not ready.
// reset (synchronous, active low) returns the parser to the first header block
// and clears extract_mode; depends on tsd_pkg and tsd_parser.
`default_nettype none

module tar_stream_deframer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // in_byte
    input  wire logic                        s_axis_tlast,  // end_of_input
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // out_byte[7:0], member_size[40:8], error_code[42:41], blocks_seen[74:43], zeros
    output      logic [tsd_pkg::TDATA_W-1:0] m_axis_tdata,
    output      logic [2:0]                  m_axis_tuser,  // kind
    output      logic                        m_axis_tlast,  // last_of_member
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready
);
    import tsd_pkg::*;

    logic       r_extract_mode;
    logic       r_out_valid;
    t_result    r_out;
    t_result    result;
    logic       accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (s_axis_tdata),
        .i_eoi          (s_axis_tlast),
        .i_extract_mode (r_extract_mode),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_of_member;
    assign m_axis_tdata  = {{(TDATA_W-8-SIZE_W-2-BLK_W){1'b0}},
                            r_out.blocks_seen,
                            r_out.error_code,
                            r_out.member_size,
                            r_out.out_byte};

    // register index is the word address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extract_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXTRACT) begin
            r_extract_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXTRACT) ? {31'd0, r_extract_mode} : 32'd0;

endmodule

`default_nettype wire

// ----- src/tsd_parser.sv -----
// byte-wise ustar parser: block framing, header decode, data and pad skipping
// depends on tsd_pkg; result is combinational from the state and the current word
`default_nettype none

module tsd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eoi,
    input  wire logic            i_extract_mode,
    output tsd_pkg::t_result     o_result
);
    import tsd_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        SP_SKIP   = 3'b001,
        SP_DIGITS = 3'b010,
        SP_STOP   = 3'b100
    } t_sp;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h73; // s
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    t_phase             r_phase, n_phase;
    t_sp                r_sp, n_sp;
    logic [OFF_W-1:0]   r_offset, n_offset;
    logic               r_first, n_first;
    logic               r_magic_ok, n_magic_ok;
    logic               r_block_nonzero, n_block_nonzero;
    logic [1:0]         r_zero_run, n_zero_run;
    logic [SIZE_W-1:0]  r_size_accum, n_size_accum;
    logic [7:0]         r_type_byte, n_type_byte;
    logic [SIZE_W-1:0]  r_data_left, n_data_left;
    logic [OFF_W-1:0]   r_pad_left, n_pad_left;
    logic [BLK_W-1:0]   r_blocks_read, n_blocks_read;

    logic               wrap;
    logic [OFF_W-1:0]   offset_adv;
    logic [BLK_W-1:0]   blocks_adv;
    logic               nonzero;
    logic               is_octal;
    logic               is_space;
    logic               in_magic;
    logic               in_size;
    logic [2:0]         magic_idx;
    logic [1:0]         zero_inc;
    logic [SIZE_W-1:0]  data_dec;
    logic [OFF_W-1:0]   pad_dec;
    t_result            res;

    assign wrap       = (r_offset == LAST_OFFSET);
    assign offset_adv = wrap ? '0 : r_offset + OFF_W'(1);
    assign blocks_adv = wrap ? r_blocks_read + BLK_W'(1) : r_blocks_read;
    assign nonzero    = r_block_nonzero | (i_byte != 8'h00);
    assign is_octal   = (i_byte[7:3] == 5'b00110);
    assign is_space   = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0d);
    assign in_magic   = (r_offset >= MAGIC_START) && (r_offset < MAGIC_END);
    assign in_size    = (r_offset >= SIZE_START) && (r_offset < SIZE_END);
    assign magic_idx  = 3'(r_offset - MAGIC_START);
    assign zero_inc   = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
    assign data_dec   = (r_data_left != '0) ? r_data_left - SIZE_W'(1) : '0;
    assign pad_dec    = (r_pad_left != '0) ? r_pad_left - OFF_W'(1) : '0;

    always_comb begin
        n_phase         = r_phase;
        n_sp            = r_sp;
        n_offset        = r_offset;
        n_first         = r_first;
        n_magic_ok      = r_magic_ok;
        n_block_nonzero = r_block_nonzero;
        n_zero_run      = r_zero_run;
        n_size_accum    = r_size_accum;
        n_type_byte     = r_type_byte;
        n_data_left     = r_data_left;
        n_pad_left      = r_pad_left;
        n_blocks_read   = r_blocks_read;
        res             = '0;
        res.kind        = KIND_NONE;
        res.error_code  = ERR_UNSUPPORTED;

        case (r_phase)
            PH_DONE: begin
            end
            PH_HEADER: begin
                if (i_eoi) begin
                    n_phase = PH_DONE;
                    if (r_first) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NOT_TAR;
                    end else if (r_zero_run == 2'd1) begin
                        res.kind        = KIND_ERROR;
                        res.error_code  = ERR_LONE_ZERO;
                        res.blocks_seen = r_blocks_read;
                    end
                end else begin
                    n_block_nonzero = nonzero;
                    if (r_first && in_magic && i_byte != magic_char(magic_idx)) begin
                        n_magic_ok = 1'b0;
                    end
                    if (in_size) begin
                        case (r_sp)
                            SP_SKIP: begin
                                if (!is_space) begin
                                    if (is_octal) begin
                                        n_size_accum = {{(SIZE_W-3){1'b0}}, i_byte[2:0]};
                                        n_sp         = SP_DIGITS;
                                    end else begin
                                        n_sp = SP_STOP;
                                    end
                                end
                            end
                            SP_DIGITS: begin
                                if (is_octal) begin
                                    // shifting out set bits means the value saturates
                                    n_size_accum = (r_size_accum[SIZE_W-1:SIZE_W-3] != 3'b000)
                                                 ? SIZE_MAX
                                                 : {r_size_accum[SIZE_W-4:0], i_byte[2:0]};
                                end else begin
                                    n_sp = SP_STOP;
                                end
                            end
                            SP_STOP: begin
                            end
                            default: n_sp = SP_STOP;
                        endcase
                    end
                    if (r_offset == TYPE_OFFSET) begin
                        n_type_byte = i_byte;
                    end
                    n_offset      = offset_adv;
                    n_blocks_read = blocks_adv;
                    if (wrap) begin
                        // header block complete
                        n_first         = 1'b0;
                        n_block_nonzero = 1'b0;
                        n_size_accum    = '0;
                        n_sp            = SP_SKIP;
                        n_type_byte     = '0;
                        if (r_first && !r_magic_ok) begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NOT_TAR;
                            n_phase        = PH_DONE;
                        end else if (!nonzero) begin
                            n_zero_run = zero_inc;
                            if (zero_inc == 2'd2) begin
                                res.kind = KIND_END;
                                n_phase  = PH_DONE;
                            end
                        end else begin
                            n_zero_run = 2'd0;
                            if (r_type_byte != CHAR_ZERO && r_type_byte != CHAR_NUL) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_UNSUPPORTED;
                                n_phase        = PH_DONE;
                            end else begin
                                res.kind        = KIND_HEADER;
                                res.member_size = r_size_accum;
                                if (r_size_accum != '0) begin
                                    n_data_left = r_size_accum;
                                    // pad is the distance to the next block boundary
                                    n_pad_left  = OFF_W'(~r_size_accum[OFF_W-1:0]) + OFF_W'(1);
                                    n_phase     = PH_DATA;
                                end
                            end
                        end
                    end
                end
            end
            PH_DATA: begin
                if (i_eoi) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNEXPECTED;
                    n_phase        = PH_DONE;
                end else begin
                    n_offset      = offset_adv;
                    n_blocks_read = blocks_adv;
                    n_data_left   = data_dec;
                    if (i_extract_mode) begin
                        res.kind           = KIND_DATA;
                        res.out_byte       = i_byte;
                        res.last_of_member = (data_dec == '0);
                    end
                    if (data_dec == '0) begin
                        n_phase = (r_pad_left != '0) ? PH_PAD : PH_HEADER;
                    end
                end
            end
            PH_PAD: begin
                if (i_eoi) begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNEXPECTED;
                    n_phase        = PH_DONE;
                end else begin
                    n_offset      = offset_adv;
                    n_blocks_read = blocks_adv;
                    n_pad_left    = pad_dec;
                    if (pad_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            default: n_phase = PH_DONE;
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEADER;
            r_sp            <= SP_SKIP;
            r_offset        <= '0;
            r_first         <= 1'b1;
            r_magic_ok      <= 1'b1;
            r_block_nonzero <= 1'b0;
            r_zero_run      <= 2'd0;
            r_size_accum    <= '0;
            r_type_byte     <= '0;
            r_data_left     <= '0;
            r_pad_left      <= '0;
            r_blocks_read   <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_sp            <= n_sp;
            r_offset        <= n_offset;
            r_first         <= n_first;
            r_magic_ok      <= n_magic_ok;
            r_block_nonzero <= n_block_nonzero;
            r_zero_run      <= n_zero_run;
            r_size_accum    <= n_size_accum;
            r_type_byte     <= n_type_byte;
            r_data_left     <= n_data_left;
            r_pad_left      <= n_pad_left;
            r_blocks_read   <= n_blocks_read;
        end
    end

endmodule

`default_nettype wire
